/* rtl/core/irn_pkg.sv */
`timescale 1ns / 1ps

package irn_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_COS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam int TRIG_W = 16;
	localparam int DIM_W = 8;
	localparam int COORD_W = 7;
	localparam int PIXEL_W = 32;
	localparam int HALF_W = 9;
	localparam int PROD_W = HALF_W + TRIG_W;
	localparam int NUM_W = 28;
	localparam int FRAC_BITS = 15;
	localparam int ONE_SHIFT = 14;
	localparam int LIN_W = 21;

	localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
	localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

	typedef struct packed {
		logic wr_en;
		logic capture;
		logic mul_en;
		logic sum_en;
		logic coord_en;
		logic load_out;
	} irn_ctl_t;

	typedef struct packed {
		logic out_free;
	} irn_stat_t;

endpackage

/* rtl/core/image_rotate_nearest.sv */
`timescale 1ns / 1ps

// Nearest-neighbor rotation of a stored frame about its center. A write beat
// (cmd 0) stores pixel_in at (col, row); writes outside the configured frame
// are dropped. A read beat (cmd 1) maps (col, row) back through the inverse
// rotation set by the REG_COS and REG_SIN registers (signed Q1.14) and returns
// the source pixel with in_range 1, or zero with in_range 0 when the point
// falls outside the frame. For a read the sequencer steps through the offset,
// multiply, sum, coordinate and frame memory read, and the load of the output
// register; it waits in the load step only while a previous result is still
// stalled in that register. Frame memory
// contents are undefined after reset, so load the whole frame before reading.
// Write configuration only while the block is idle.
module image_rotate_nearest #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int CHANNELS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [irn_pkg::COORD_W-1:0]    col,
	input  logic [irn_pkg::COORD_W-1:0]    row,
	input  logic [irn_pkg::PIXEL_W-1:0]    pixel_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [irn_pkg::PIXEL_W-1:0]    pixel_out,
	output logic                           in_range
);
	import irn_pkg::*;

	irn_ctl_t  ctl;
	irn_stat_t stat;

	irn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.ctl      (ctl),
		.stat     (stat)
	);

	irn_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CHANNELS   (CHANNELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.col       (col),
		.row       (row),
		.pixel_in  (pixel_in),
		.ctl       (ctl),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.pixel_out (pixel_out),
		.in_range  (in_range)
	);

endmodule

/* rtl/core/irn_ctrl.sv */
`timescale 1ns / 1ps

module irn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              cmd,
	output logic              in_stall,
	output irn_pkg::irn_ctl_t ctl,
	input  irn_pkg::irn_stat_t stat
);
	import irn_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_SUM   = 5'b00100,
		S_COORD = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_READ) begin
						ctl.capture = 1'b1;
						state_d = S_MUL;
					end else begin
						ctl.wr_en = 1'b1;
					end
				end
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				ctl.sum_en = 1'b1;
				state_d = S_COORD;
			end
			S_COORD: begin
				ctl.coord_en = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/irn_datapath.sv */
`timescale 1ns / 1ps

module irn_datapath #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int CHANNELS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [irn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [irn_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [irn_pkg::COORD_W-1:0]         col,
	input  logic [irn_pkg::COORD_W-1:0]         row,
	input  logic [irn_pkg::PIXEL_W-1:0]         pixel_in,
	input  irn_pkg::irn_ctl_t                   ctl,
	output irn_pkg::irn_stat_t                  stat,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [irn_pkg::PIXEL_W-1:0]         pixel_out,
	output logic                                in_range
);
	import irn_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIX_W = 8 * CHANNELS;
	localparam int W_RESET = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
	localparam int H_RESET = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;
	localparam int QUO_W = NUM_W - FRAC_BITS;

	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;
	logic [DIM_W-1:0]         w_q;
	logic [DIM_W-1:0]         h_q;
	logic [DIM_W-1:0]         cfg_dim;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;

	logic signed [HALF_W-1:0] dx2_s1;
	logic signed [HALF_W-1:0] dy2_s1;
	logic                     ok_s1;
	logic signed [PROD_W-1:0] xc_s2;
	logic signed [PROD_W-1:0] ys_s2;
	logic signed [PROD_W-1:0] yc_s2;
	logic signed [PROD_W-1:0] xs_s2;
	logic                     ok_s2;
	logic signed [NUM_W-1:0]  nx_s3;
	logic signed [NUM_W-1:0]  ny_s3;
	logic                     ok_s3;
	logic                     ok_s4;

	logic                     wr_inside;
	logic [ADDR_W-1:0]        wr_addr;
	logic [QUO_W-1:0]         qx;
	logic [QUO_W-1:0]         qy;
	logic                     x_ok;
	logic                     y_ok;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     out_valid_q;
	logic [PIXEL_W-1:0]       pixel_out_q;
	logic                     in_range_q;

	assign cfg_dim = cfg_data[DIM_W-1:0];

	// register file, sizes saturate to the store limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= SIN_RESET;
			w_q <= DIM_W'(W_RESET);
			h_q <= DIM_W'(H_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS: cos_q <= $signed(cfg_data);
				REG_SIN: sin_q <= $signed(cfg_data);
				REG_WIDTH: begin
					if (LIN_W'(cfg_dim) > LIN_W'(MAX_WIDTH)) begin
						w_q <= DIM_W'(MAX_WIDTH);
					end else begin
						w_q <= cfg_dim;
					end
				end
				REG_HEIGHT: begin
					if (LIN_W'(cfg_dim) > LIN_W'(MAX_HEIGHT)) begin
						h_q <= DIM_W'(MAX_HEIGHT);
					end else begin
						h_q <= cfg_dim;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// source write beat
	assign wr_inside = (DIM_W'(col) < w_q) && (DIM_W'(row) < h_q);
	assign wr_addr = ADDR_W'(LIN_W'(row) * LIN_W'(MAX_WIDTH) + LIN_W'(col));

	always_ff @(posedge clk) begin
		if (ctl.wr_en && wr_inside) begin
			mem[wr_addr] <= pixel_in[PIX_W-1:0];
		end
	end

	// offsets from the centre in half pixels
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			dx2_s1 <= $signed({1'b0, col, 1'b0}) - $signed({1'b0, w_q});
			dy2_s1 <= $signed({1'b0, row, 1'b0}) - $signed({1'b0, h_q});
			ok_s1 <= wr_inside;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			xc_s2 <= PROD_W'(dx2_s1) * PROD_W'(cos_q);
			ys_s2 <= PROD_W'(dy2_s1) * PROD_W'(sin_q);
			yc_s2 <= PROD_W'(dy2_s1) * PROD_W'(cos_q);
			xs_s2 <= PROD_W'(dx2_s1) * PROD_W'(sin_q);
			ok_s2 <= ok_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			nx_s3 <= NUM_W'(xc_s2) + NUM_W'(ys_s2)
				+ $signed(NUM_W'({w_q, {ONE_SHIFT{1'b0}}}));
			ny_s3 <= NUM_W'(yc_s2) - NUM_W'(xs_s2)
				+ $signed(NUM_W'({h_q, {ONE_SHIFT{1'b0}}}));
			ok_s3 <= ok_s2;
		end
	end

	// truncate toward zero, small negatives land on zero
	always_comb begin
		qx = nx_s3[NUM_W-1] ? '0 : nx_s3[NUM_W-1:FRAC_BITS];
		qy = ny_s3[NUM_W-1] ? '0 : ny_s3[NUM_W-1:FRAC_BITS];
		x_ok = (!nx_s3[NUM_W-1] || ((nx_s3[NUM_W-1:FRAC_BITS] == '1)
			&& (nx_s3[FRAC_BITS-1:0] != '0)))
			&& (qx < QUO_W'(w_q));
		y_ok = (!ny_s3[NUM_W-1] || ((ny_s3[NUM_W-1:FRAC_BITS] == '1)
			&& (ny_s3[FRAC_BITS-1:0] != '0)))
			&& (qy < QUO_W'(h_q));
		rd_addr = ADDR_W'(LIN_W'(qy[DIM_W-1:0]) * LIN_W'(MAX_WIDTH)
			+ LIN_W'(qx[DIM_W-1:0]));
	end

	always_ff @(posedge clk) begin
		if (ctl.coord_en) begin
			rd_q <= mem[rd_addr];
			ok_s4 <= ok_s3 && x_ok && y_ok;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pixel_out_q <= ok_s4 ? PIXEL_W'(rd_q) : '0;
			in_range_q <= ok_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign in_range = in_range_q;

endmodule
